/* hdl/ddoi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ddoi_pkg
// Shared types and constants for the differential-drive odometry integrator.
// ----------------------------------------------------------------------------
package ddoi_pkg;

    // operation codes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_VEL   = 2'd1,
        OP_JUMP  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [2:0] REG_TIME_STEP  = 3'd0;
    localparam logic [2:0] REG_MIN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MAX_HEIGHT = 3'd2;
    localparam logic [2:0] REG_JUMP_SPEED = 3'd3;
    localparam logic [2:0] REG_START_X    = 3'd4;
    localparam logic [2:0] REG_START_Y    = 3'd5;
    localparam logic [2:0] REG_START_Z    = 3'd6;

    localparam logic signed [31:0] PI_Q       = 32'sd843314857;
    localparam logic signed [31:0] TWO_PI_Q   = 32'sd1686629713;
    localparam logic signed [31:0] HALF_PI_Q  = 32'sd421657428;
    localparam logic signed [31:0] GAIN_Q30   = 32'sd652032874;
    localparam logic signed [23:0] GRAV_STEP  = 24'sd6423;
    localparam logic [15:0]        HOP_STEP   = 16'd655;

    // arctangent table, Q3.28
    function automatic logic signed [31:0] atan_lut(input logic [4:0] i);
        logic signed [31:0] v;
        unique case (i)
            5'd0:  v = 32'sd210828714;
            5'd1:  v = 32'sd124459457;
            5'd2:  v = 32'sd65760959;
            5'd3:  v = 32'sd33381290;
            5'd4:  v = 32'sd16755422;
            5'd5:  v = 32'sd8385879;
            5'd6:  v = 32'sd4193963;
            5'd7:  v = 32'sd2097109;
            5'd8:  v = 32'sd1048571;
            5'd9:  v = 32'sd524287;
            default: v = (i >= 5'd29) ? 32'sd0 : (32'sd1 <<< (5'd28 - i));
        endcase
        return v;
    endfunction

    // controller to datapath commands
    typedef enum logic [3:0] {
        DP_IDLE,
        DP_LATCH,     // velocity command
        DP_JUMP,      // jump request
        DP_PRESET,    // tick before any command
        DP_CINIT,     // CORDIC start + fold
        DP_CSTEP,     // one CORDIC iteration
        DP_VEL,       // roll * cos/sin
        DP_POS,       // position/yaw products
        DP_ACC,       // sums and saturation
        DP_HOP,       // hop product
        DP_DONE       // hop landing, load output
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t cmd;
    } dp_ctl_t;

    typedef struct packed {
        logic cordic_last;
    } dp_sts_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CINIT, S_CSTEP, S_VEL, S_POS, S_ACC, S_HOP, S_DONE, S_OUT
    } state_t;

endpackage
`default_nettype wire

/* hdl/ddoi_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ddoi_datapath
// State registers, iterative CORDIC and product/saturation datapath.
// ----------------------------------------------------------------------------
module ddoi_datapath #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  ddoi_pkg::dp_ctl_t    ctl,
    output ddoi_pkg::dp_sts_t    sts,
    input  wire  [18:0]          in_left,
    input  wire  [18:0]          in_right,
    input  wire  [18:0]          in_climb,
    input  wire  [15:0]          time_step,
    input  wire  signed [31:0]   z_floor,
    input  wire  signed [31:0]   z_ceil,
    input  wire  [19:0]          jump_speed,
    input  wire  signed [31:0]   start_x,
    input  wire  signed [31:0]   start_y,
    input  wire  signed [31:0]   start_z,
    output logic [256:0]         res_word
);
    import ddoi_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam logic [4:0] LAST = 5'(STEPS - 1);

    // architectural state
    logic               seen_reg, air_reg;
    logic signed [18:0] left_reg, right_reg, climb_reg;
    logic signed [23:0] rise_reg;
    logic signed [31:0] x_reg, y_reg, z_reg, yaw_reg, hop_reg;
    // CORDIC state
    logic signed [33:0] cx_reg, cy_reg, ang_reg;
    logic               flip_reg;
    logic [4:0]         it_reg;
    // intermediate registers
    logic signed [18:0] roll_reg, vx_reg, vy_reg;
    logic signed [63:0] px_reg, py_reg, pz_reg, pw_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg, oyaw_reg, ohop_reg;
    logic signed [18:0] ovx_reg, ovy_reg, ovz_reg, oroll_reg;
    logic signed [21:0] oom_reg;

    logic signed [21:0] omega;
    logic signed [19:0] roll_sum;
    logic signed [33:0] cos_v, sin_v;
    logic signed [16:0] ts_s;

    assign omega    = 22'(($signed({{3{right_reg[18]}}, right_reg})
                      - $signed({{3{left_reg[18]}}, left_reg})) <<< 1);
    assign roll_sum = $signed({left_reg[18], left_reg}) + $signed({right_reg[18], right_reg});
    assign cos_v    = flip_reg ? -cx_reg : cx_reg;
    assign sin_v    = flip_reg ? -cy_reg : cy_reg;
    assign ts_s     = $signed({1'b0, time_step});
    assign sts.cordic_last = (it_reg == LAST);

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                               input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                               input int w);
        logic signed [63:0] hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    logic signed [63:0] t0, t1, t2, zt, yt, ht, rt;
    logic signed [33:0] dx, dy;

    always_comb begin
        dx = cx_reg >>> it_reg;
        dy = cy_reg >>> it_reg;
        t0 = sat(64'(x_reg) + rnd(px_reg, 16), 32);
        t1 = sat(64'(y_reg) + rnd(py_reg, 16), 32);
        zt = sat(64'(z_reg) + rnd(pz_reg, 16), 32);
        if (zt > 64'(z_ceil)) zt = 64'(z_ceil);
        if (zt < 64'(z_floor)) zt = 64'(z_floor);
        yt = 64'(yaw_reg) + rnd(pw_reg, 4);
        if (yt > 64'(PI_Q)) yt = yt - 64'(TWO_PI_Q);
        else if (yt < -64'(PI_Q)) yt = yt + 64'(TWO_PI_Q);
        if (yt > 64'(PI_Q)) yt = 64'(PI_Q);
        if (yt < -64'(PI_Q)) yt = -64'(PI_Q);
        rt = sat(64'(rise_reg) - 64'(GRAV_STEP), 24);
        t2 = sat(64'(hop_reg) + rnd(px_reg, 16), 32);
        ht = t2;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
            air_reg  <= 1'b0;
            it_reg   <= '0;
        end else begin
            unique case (ctl.cmd)
                DP_LATCH, DP_JUMP: begin
                    seen_reg <= 1'b1;
                    if (ctl.cmd == DP_JUMP && !air_reg) air_reg <= 1'b1;
                end
                DP_CINIT: it_reg <= '0;
                DP_CSTEP: it_reg <= it_reg + 5'd1;
                // landing is decided once the hop product is in place
                DP_DONE:  if (air_reg && ht <= 0) air_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // payload state and arithmetic
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0; right_reg <= '0; climb_reg <= '0; rise_reg <= '0;
            x_reg <= start_x; y_reg <= start_y; z_reg <= start_z;
            yaw_reg <= '0; hop_reg <= '0;
        end else begin
            unique case (ctl.cmd)
                DP_LATCH, DP_JUMP: begin
                    if (!seen_reg) begin
                        x_reg <= start_x; y_reg <= start_y; z_reg <= start_z;
                        yaw_reg <= '0;
                    end
                    if (ctl.cmd == DP_LATCH) begin
                        left_reg  <= $signed(in_left);
                        right_reg <= $signed(in_right);
                        climb_reg <= $signed(in_climb);
                    end else if (!air_reg) begin
                        rise_reg <= $signed({4'd0, jump_speed});
                    end
                end
                DP_PRESET: begin
                    ox_reg <= start_x; oy_reg <= start_y; oz_reg <= start_z;
                    oyaw_reg <= '0; ovx_reg <= '0; ovy_reg <= '0; ovz_reg <= '0;
                    oom_reg <= '0; oroll_reg <= '0; ohop_reg <= '0;
                end
                DP_CINIT: begin
                    cx_reg <= 34'(GAIN_Q30);
                    cy_reg <= '0;
                    roll_reg <= 19'(roll_sum >>> 1);
                    if (yaw_reg > HALF_PI_Q) begin
                        ang_reg <= 34'(yaw_reg) - 34'(PI_Q); flip_reg <= 1'b1;
                    end else if (yaw_reg < -HALF_PI_Q) begin
                        ang_reg <= 34'(yaw_reg) + 34'(PI_Q); flip_reg <= 1'b1;
                    end else begin
                        ang_reg <= 34'(yaw_reg); flip_reg <= 1'b0;
                    end
                end
                DP_CSTEP: begin
                    if (!ang_reg[33]) begin
                        cx_reg <= cx_reg - dy; cy_reg <= cy_reg + dx;
                        ang_reg <= ang_reg - 34'(atan_lut(it_reg));
                    end else begin
                        cx_reg <= cx_reg + dy; cy_reg <= cy_reg - dx;
                        ang_reg <= ang_reg + 34'(atan_lut(it_reg));
                    end
                end
                DP_VEL: begin
                    vx_reg <= 19'(sat(rnd(64'(roll_reg) * 64'(cos_v), 30), 19));
                    vy_reg <= 19'(sat(rnd(64'(roll_reg) * 64'(sin_v), 30), 19));
                end
                DP_POS: begin
                    px_reg <= 64'(vx_reg) * 64'(ts_s);
                    py_reg <= 64'(vy_reg) * 64'(ts_s);
                    pz_reg <= 64'(climb_reg) * 64'(ts_s);
                    pw_reg <= 64'(omega) * 64'(ts_s);
                end
                DP_ACC: begin
                    x_reg <= 32'(t0); y_reg <= 32'(t1); z_reg <= 32'(zt);
                    yaw_reg <= 32'(yt);
                    if (air_reg) rise_reg <= 24'(rt);
                end
                DP_HOP: begin
                    // px_reg reused for the hop product
                    px_reg <= 64'(rise_reg) * 64'($signed({1'b0, HOP_STEP}));
                end
                DP_DONE: begin
                    if (air_reg) hop_reg <= (ht <= 0) ? 32'sd0 : 32'(ht);
                    else hop_reg <= '0;
                    ox_reg <= x_reg; oy_reg <= y_reg; oz_reg <= z_reg;
                    oyaw_reg <= yaw_reg; ovx_reg <= vx_reg; ovy_reg <= vy_reg;
                    ovz_reg <= climb_reg; oom_reg <= omega; oroll_reg <= roll_reg;
                    ohop_reg <= air_reg ? ((ht <= 0) ? 32'sd0 : 32'(ht)) : 32'sd0;
                end
                default: ;
            endcase
        end
    end

    assign res_word = {ohop_reg, oroll_reg, oom_reg, ovz_reg, ovy_reg, ovx_reg,
                       oyaw_reg[30:0], oz_reg, oy_reg, ox_reg};
endmodule
`default_nettype wire

/* hdl/ddoi_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ddoi_ctrl
// Sequencer: accepts one word, steps the datapath, holds the result word.
// ----------------------------------------------------------------------------
module ddoi_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  ddoi_pkg::op_t       in_op,
    input  wire                 seen,
    output logic                out_valid,
    input  wire                 out_ready,
    output ddoi_pkg::dp_ctl_t   ctl,
    input  ddoi_pkg::dp_sts_t   sts
);
    import ddoi_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        ctl.cmd    = DP_IDLE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    unique case (in_op)
                        OP_VEL:  ctl.cmd = DP_LATCH;
                        OP_JUMP: ctl.cmd = DP_JUMP;
                        OP_TICK: state_next = seen ? S_CINIT : S_OUT;
                        default: ;
                    endcase
                end
            end
            S_CINIT: begin ctl.cmd = DP_CINIT; state_next = S_CSTEP; end
            S_CSTEP: begin
                ctl.cmd = DP_CSTEP;
                if (sts.cordic_last) state_next = S_VEL;
            end
            S_VEL: begin ctl.cmd = DP_VEL; state_next = S_POS; end
            S_POS: begin ctl.cmd = DP_POS; state_next = S_ACC; end
            S_ACC: begin ctl.cmd = DP_ACC; state_next = S_HOP; end
            S_HOP: begin ctl.cmd = DP_HOP; state_next = S_DONE; end
            S_DONE: begin
                if (!ov_reg || out_ready) begin
                    ctl.cmd    = DP_DONE;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_OUT: begin
                if (!ov_reg || out_ready) begin
                    ctl.cmd    = DP_PRESET;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
endmodule
`default_nettype wire

/* hdl/diff_drive_odometry_integrator_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_odometry_integrator_unit
// Fixed-point differential-drive odometry with hop and height clamp.
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_axis   in   tdata: operation, left, right, climb speeds
// m_axis   out  tdata: pose, speeds, turn rate, hop height
// cfg      in   wr_en / wr_index / wr_data
//
// A tick runs an iterative CORDIC (one step a cycle), then the velocity, product,
// sum, hop and output states. Commands are taken while idle; a tick before any command presets the result.
// The result register frees the input once loaded; a stalled result holds
// the sequencer only at its final load. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module diff_drive_odometry_integrator_unit #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [63:0]  s_tdata,   // operation[1:0], left[20:2], right[39:21], climb[58:40]
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [263:0] m_tdata,   // pos_x, pos_y, pos_z, heading, vel_x, vel_y,
                                    // vel_z, turn_rate, mean wheel speed, hop_height
    input  wire          wr_en,
    input  wire  [2:0]   wr_index,
    input  wire  [31:0]  wr_data
);
    import ddoi_pkg::*;

    logic [15:0]        ts_reg;
    logic signed [31:0] minh_reg, maxh_reg, sx_reg, sy_reg, sz_reg;
    logic [19:0]        js_reg;
    dp_ctl_t            ctl;
    dp_sts_t            sts;
    logic [256:0]       res;
    logic               seen;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg <= 16'd655; minh_reg <= 32'sd13107; maxh_reg <= 32'sd65536;
            js_reg <= 20'd262144; sx_reg <= 32'sd98304; sy_reg <= -32'sd32768;
            sz_reg <= 32'sd65536;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_TIME_STEP:  ts_reg   <= wr_data[15:0];
                REG_MIN_HEIGHT: minh_reg <= wr_data;
                REG_MAX_HEIGHT: maxh_reg <= wr_data;
                REG_JUMP_SPEED: js_reg   <= wr_data[19:0];
                REG_START_X:    sx_reg   <= wr_data;
                REG_START_Y:    sy_reg   <= wr_data;
                REG_START_Z:    sz_reg   <= wr_data;
                default: ;
            endcase
        end
    end

    // command-seen flag mirrored for the sequencer
    logic seen_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) seen_reg <= 1'b0;
        else if (ctl.cmd == DP_LATCH || ctl.cmd == DP_JUMP) seen_reg <= 1'b1;
    end
    assign seen = seen_reg;

    ddoi_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid (s_tvalid), .in_ready (s_tready),
        .in_op    (op_t'(s_tdata[1:0])), .seen,
        .out_valid(m_tvalid), .out_ready(m_tready),
        .ctl, .sts
    );

    ddoi_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .aclk, .aresetn, .ctl, .sts,
        .in_left(s_tdata[20:2]), .in_right(s_tdata[39:21]), .in_climb(s_tdata[58:40]),
        .time_step(ts_reg), .z_floor(minh_reg), .z_ceil(maxh_reg),
        .jump_speed(js_reg), .start_x(sx_reg), .start_y(sy_reg), .start_z(sz_reg),
        .res_word(res)
    );

    assign m_tdata = {7'd0, res};

    // result held while the receiver stalls; no word accepted during CORDIC steps
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.cmd == DP_CSTEP |-> !s_tready) else $error("accept while busy");
endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Odometry integrator testbench
// Drives commands, jumps and ticks into the integrator, predicts each pose
// word with a local fixed-point model and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
    import ddoi_pkg::*;

    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] hop;
        logic signed [18:0] roll;
        logic signed [21:0] turn;
        logic signed [18:0] vz;
        logic signed [18:0] vy;
        logic signed [18:0] vx;
        logic signed [30:0] yaw;
        logic signed [31:0] pz;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } pose_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [263:0] m_tdata;
    logic         wr_en;
    logic [2:0]   wr_index;
    logic [31:0]  wr_data;

    diff_drive_odometry_integrator_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    // predictor state and register copies
    longint ts, hmin, hmax, jspd, sx0, sy0, sz0;
    bit     seen, in_air;
    longint hl, hr, hc, rise, px, py, pz, yaw, hop;

    pose_t  pose_q[$];
    int     errors;
    int     idle_cycles;
    bit     rx_stall_mode;
    int     rx_hold;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint sext(longint v, int w);
        longint m;
        m = (64'sd1 << w) - 1;
        v = v & m;
        if (v[w-1]) v = v - (64'sd1 << w);
        return v;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, int w);
        longint hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint atan_val(int i);
        longint t[10];
        t = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
              4193963, 2097109, 1048571, 524287};
        if (i < 10) return t[i];
        if (i >= 29) return 0;
        return 64'sd1 << (28 - i);
    endfunction

    // rotation by iterative shift-add, angle folded into +-pi/2
    task automatic sin_cos(input longint ang, output longint c, output longint s);
        longint x, y, nx;
        bit flip;
        x = 652032874; y = 0; flip = 0;
        if (ang > 421657428) begin
            ang -= 843314857; flip = 1;
        end else if (ang < -421657428) begin
            ang += 843314857; flip = 1;
        end
        for (int i = 0; i < 24; i++) begin
            if (ang >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); ang -= atan_val(i);
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); ang += atan_val(i);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_reset();
        ts = 655; hmin = 13107; hmax = 65536; jspd = 262144;
        sx0 = 98304; sy0 = -32768; sz0 = 65536;
        seen = 0; in_air = 0; hl = 0; hr = 0; hc = 0; rise = 0;
        px = sx0; py = sy0; pz = sz0; yaw = 0; hop = 0;
    endtask

    task automatic note_command();
        if (!seen) begin
            px = sx0; py = sy0; pz = sz0; yaw = 0; seen = 1;
        end
    endtask

    // advance the pose model by one accepted word
    task automatic predict_word(input logic [63:0] d);
        op_t    op;
        pose_t  p;
        longint roll, c, s, vx, vy, z, om, h, ny;
        op = op_t'(d[1:0]);
        p = '0;
        case (op)
            OP_VEL: begin
                note_command();
                hl = sext(d[20:2], 19); hr = sext(d[39:21], 19); hc = sext(d[58:40], 19);
            end
            OP_JUMP: begin
                note_command();
                if (!in_air) begin
                    in_air = 1; rise = jspd;
                end
            end
            OP_TICK: begin
                if (!seen) begin
                    p.px = 32'(sx0); p.py = 32'(sy0); p.pz = 32'(sz0);
                end else begin
                    roll = (hl + hr) >>> 1;
                    sin_cos(yaw, c, s);
                    vx = clip(round_shift(roll * c, 30), 19);
                    vy = clip(round_shift(roll * s, 30), 19);
                    px = clip(px + round_shift(vx * ts, 16), 32);
                    py = clip(py + round_shift(vy * ts, 16), 32);
                    z = clip(pz + round_shift(hc * ts, 16), 32);
                    if (z > hmax) z = hmax;
                    if (z < hmin) z = hmin;
                    pz = z;
                    om = 2 * (hr - hl);
                    if (in_air) begin
                        rise = clip(rise - 6423, 24);
                        h = clip(hop + round_shift(rise * 655, 16), 32);
                        if (h <= 0) begin
                            h = 0; in_air = 0;
                        end
                        hop = h;
                    end else begin
                        hop = 0;
                    end
                    ny = yaw + round_shift(om * ts, 4);
                    if (ny > 843314857) ny -= 1686629713;
                    else if (ny < -843314857) ny += 1686629713;
                    if (ny > 843314857) ny = 843314857;
                    if (ny < -843314857) ny = -843314857;
                    yaw = ny;
                    p.px = 32'(px); p.py = 32'(py); p.pz = 32'(pz); p.yaw = 31'(yaw);
                    p.vx = 19'(vx); p.vy = 19'(vy); p.vz = 19'(hc); p.turn = 22'(om);
                    p.roll = 19'(roll); p.hop = 32'(hop);
                end
                pose_q.push_back(p);
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    // send one word through the input handshake; valid stays up for a
    // back-to-back word and is dropped only before a gap or by drain
    task automatic send_word(input op_t op, input longint l, input longint r,
                             input longint cl, input bit gaps);
        logic [63:0] d;
        int g;
        d = '0;
        d[1:0] = op; d[20:2] = l[18:0]; d[39:21] = r[18:0]; d[58:40] = cl[18:0];
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_word(d);
    endtask

    task automatic write_reg(input logic [2:0] idx, input longint v);
        wr_en <= 1'b1; wr_index <= idx; wr_data <= v[31:0];
        @(posedge aclk);
        wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_TIME_STEP:  ts = v & 16'hFFFF;
            REG_MIN_HEIGHT: hmin = sext(v, 32);
            REG_MAX_HEIGHT: hmax = sext(v, 32);
            REG_JUMP_SPEED: jspd = v & 20'hFFFFF;
            REG_START_X:    sx0 = sext(v, 32);
            REG_START_Y:    sy0 = sext(v, 32);
            REG_START_Z:    sz0 = sext(v, 32);
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pose_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic longint rand_speed();
        case ($urandom_range(0, 5))
            0: return -262144;
            1: return 262143;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $signed($urandom_range(0, 524287)) - 262144;
        endcase
    endfunction

    // directed: ticks before a command, extremes, jumps, ignored opcode
    task automatic test_directed();
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_NONE, -1, -1, -1, 0);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_VEL, 262143, 262143, 262143, 0);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_VEL, -262144, 262143, -262144, 0);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_JUMP, 0, 0, 0, 0);
        send_word(OP_JUMP, 0, 0, 0, 0);
        repeat (6) send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_VEL, 262143, -262144, 0, 0);
        repeat (4) send_word(OP_TICK, 0, 0, 0, 0);
        drain();
    endtask

    // registers at extremes: saturation, clamp and yaw limits
    task automatic test_registers();
        write_reg(REG_TIME_STEP, 65535);
        write_reg(REG_MIN_HEIGHT, -2147483648);
        write_reg(REG_MAX_HEIGHT, 2147483647);
        write_reg(REG_JUMP_SPEED, 1048575);
        write_reg(REG_START_X, 2147483647);
        write_reg(REG_START_Y, -2147483648);
        write_reg(REG_START_Z, 2147483600);
        send_word(OP_TICK, 0, 0, 0, 0);
        send_word(OP_JUMP, 0, 0, 0, 0);
        send_word(OP_VEL, 262143, 262143, 262143, 0);
        repeat (30) send_word(OP_TICK, 0, 0, 0, 1);
        send_word(OP_VEL, -262144, 262143, -262144, 0);
        repeat (10) send_word(OP_TICK, 0, 0, 0, 1);
        drain();
        write_reg(REG_TIME_STEP, 0);
        write_reg(REG_MIN_HEIGHT, 2147483647);
        write_reg(REG_MAX_HEIGHT, -2147483648);
        write_reg(REG_JUMP_SPEED, 0);
        send_word(OP_JUMP, 0, 0, 0, 0);
        repeat (5) send_word(OP_TICK, 0, 0, 0, 1);
        drain();
    endtask

    // random phases with different register settings
    task automatic test_random();
        longint cfg_ts;
        int     r;
        for (int ph = 0; ph < 8; ph++) begin
            cfg_ts = (ph % 3 == 0) ? $urandom_range(0, 65535) : $urandom_range(100, 3000);
            write_reg(REG_TIME_STEP, cfg_ts);
            write_reg(REG_MIN_HEIGHT, $signed($urandom_range(0, 131072)) - 65536);
            write_reg(REG_MAX_HEIGHT, $urandom_range(0, 400000));
            write_reg(REG_JUMP_SPEED, $urandom_range(0, 1048575));
            write_reg(REG_START_X, $urandom());
            write_reg(REG_START_Y, $urandom());
            write_reg(REG_START_Z, $signed($urandom_range(0, 200000)) - 50000);
            rx_stall_mode = ph[0];
            for (int k = 0; k < 220; k++) begin
                r = $urandom_range(0, 99);
                if (r < 60) send_word(OP_TICK, rand_speed(), rand_speed(), rand_speed(), 1);
                else if (r < 82) send_word(OP_VEL, rand_speed(), rand_speed(), rand_speed(), 1);
                else if (r < 95) send_word(OP_JUMP, rand_speed(), rand_speed(), rand_speed(), 1);
                else send_word(OP_NONE, rand_speed(), rand_speed(), rand_speed(), 1);
                if (k == 100) drain();
            end
            drain();
        end
    endtask

    // result side: random stalls, compare against oldest prediction
    always @(posedge aclk) begin
        pose_t g, w;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                g = m_tdata[256:0];
                if (pose_q.size() == 0) begin
                    report("unexpected word", 0, 0);
                end else begin
                    w = pose_q.pop_front();
                    if (g.px !== w.px) report("pos_x", g.px, w.px);
                    if (g.py !== w.py) report("pos_y", g.py, w.py);
                    if (g.pz !== w.pz) report("pos_z", g.pz, w.pz);
                    if (g.yaw !== w.yaw) report("heading", g.yaw, w.yaw);
                    if (g.vx !== w.vx) report("vel_x", g.vx, w.vx);
                    if (g.vy !== w.vy) report("vel_y", g.vy, w.vy);
                    if (g.vz !== w.vz) report("vel_z", g.vz, w.vz);
                    if (g.turn !== w.turn) report("turn_rate", g.turn, w.turn);
                    if (g.roll !== w.roll) report("mean wheel speed", g.roll, w.roll);
                    if (g.hop !== w.hop) report("hop_height", g.hop, w.hop);
                end
            end
            if (!rx_stall_mode) begin
                m_tready <= 1'b1;
            end else if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 29) == 0) begin
                rx_hold = $urandom_range(10, 60);
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    // watchdog on handshake inactivity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCH_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        errors = 0; idle_cycles = 0; rx_stall_mode = 0; rx_hold = 0;
        aresetn <= 1'b0; s_tvalid <= 1'b0; s_tdata <= '0;
        wr_en <= 1'b0; wr_index <= '0; wr_data <= '0;
        predict_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_registers();
        test_random();
        drain();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* sim.f */
hdl/ddoi_pkg.sv
hdl/ddoi_datapath.sv
hdl/ddoi_ctrl.sv
hdl/diff_drive_odometry_integrator_unit.sv
test/testbench.sv
